/* rtl/core/kpd_pkg.sv */
package kpd_pkg;

    localparam int NUM_KEYS    = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W = 3;

    // item modes
    localparam logic [1:0] MODE_SCAN  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_RELOAD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SHIFT_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SHIFT_MASK = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] raw_keys;
    } kpd_in_t;

    typedef struct packed {
        logic [15:0] key_code;
        logic        code_valid;
        logic [4:0]  queue_count;
    } kpd_out_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_FLUSH = 2'd3
    } kpd_op_t;

    typedef struct packed {
        kpd_op_t             op;
        logic [NUM_KEYS-1:0] code;
    } kpd_cmd_t;

endpackage

/* rtl/core/kpd_front.sv */
module kpd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_fire,
    input  kpd_pkg::kpd_in_t               in_data,
    output kpd_pkg::kpd_cmd_t              cmd
);
    import kpd_pkg::*;

    logic                long_enable_reg;
    logic [7:0]          long_threshold_reg;
    logic [7:0]          long_reload_reg;
    logic [NUM_KEYS-1:0] long_shift_mask_reg;
    logic [NUM_KEYS-1:0] short_shift_mask_reg;

    logic [NUM_KEYS-1:0] prev_scan_reg, prev_scan_next;
    logic [NUM_KEYS-1:0] prev_stable_reg, prev_stable_next;
    logic [NUM_KEYS-1:0] shift_latch_reg, shift_latch_next;
    logic [NUM_KEYS-1:0] long_mask_reg, long_mask_next;
    logic [7:0]          press_timer_reg, press_timer_next;

    logic [NUM_KEYS-1:0] now_keys;
    logic [NUM_KEYS-1:0] stable;
    logic [NUM_KEYS-1:0] rel;
    logic [NUM_KEYS-1:0] held_code;
    logic [7:0]          timer_inc;
    logic                has_plain;
    logic                has_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_enable_reg      <= 1'b1;
            long_threshold_reg   <= 8'd50;
            long_reload_reg      <= 8'd0;
            long_shift_mask_reg  <= '0;
            short_shift_mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LONG_ENABLE:      long_enable_reg      <= cfg_data[0];
                CFG_LONG_THRESHOLD:   long_threshold_reg   <= cfg_data[7:0];
                CFG_LONG_RELOAD:      long_reload_reg      <= cfg_data[7:0];
                CFG_LONG_SHIFT_MASK:  long_shift_mask_reg  <= NUM_KEYS'(cfg_data);
                CFG_SHORT_SHIFT_MASK: short_shift_mask_reg <= NUM_KEYS'(cfg_data);
                default:              ;
            endcase
        end
    end

    // sample-and-hold debounce: a key changes only when two samples agree
    assign now_keys  = NUM_KEYS'(in_data.raw_keys);
    assign stable    = (prev_scan_reg & now_keys)
                     | (prev_stable_reg & (prev_scan_reg ^ now_keys));
    assign rel       = prev_stable_reg & ~stable;
    assign held_code = stable | shift_latch_reg;
    assign timer_inc = press_timer_reg + 8'd1;
    assign has_plain = |(stable & ~long_shift_mask_reg);
    assign has_shift = |(stable & long_shift_mask_reg & ~long_mask_reg);

    always_comb
    begin
        prev_scan_next   = prev_scan_reg;
        prev_stable_next = prev_stable_reg;
        shift_latch_next = shift_latch_reg;
        long_mask_next   = long_mask_reg;
        press_timer_next = press_timer_reg;
        cmd.op           = OP_NONE;
        cmd.code         = '0;

        case (in_data.mode)
            MODE_SCAN:
            begin
                prev_scan_next   = now_keys;
                prev_stable_next = stable;
                // long press and release never hit the same tick
                if (long_enable_reg)
                begin
                    if (stable == prev_stable_reg && stable != '0)
                    begin
                        press_timer_next = timer_inc;
                        if (timer_inc >= long_threshold_reg)
                        begin
                            if (has_plain)
                            begin
                                cmd.op   = OP_PUSH;
                                cmd.code = held_code;
                            end
                            else if (has_shift)
                            begin
                                cmd.op   = OP_PUSH;
                                cmd.code = ~held_code;
                            end
                            press_timer_next = 8'd0;
                            long_mask_next   = stable;
                        end
                    end
                    else
                    begin
                        press_timer_next = long_reload_reg;
                    end
                end
                if (rel != '0)
                begin
                    if ((rel & ~long_mask_reg) != '0 && stable == '0)
                    begin
                        shift_latch_next = shift_latch_reg ^ (rel & short_shift_mask_reg);
                        cmd.op   = OP_PUSH;
                        cmd.code = rel | shift_latch_next | prev_stable_reg;
                    end
                    else
                    begin
                        long_mask_next = '0;
                    end
                end
            end
            MODE_POP:   cmd.op = OP_POP;
            MODE_FLUSH: cmd.op = OP_FLUSH;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_scan_reg   <= '0;
            prev_stable_reg <= '0;
            shift_latch_reg <= '0;
            long_mask_reg   <= '0;
            press_timer_reg <= '0;
        end
        else if (in_fire)
        begin
            prev_scan_reg   <= prev_scan_next;
            prev_stable_reg <= prev_stable_next;
            shift_latch_reg <= shift_latch_next;
            long_mask_reg   <= long_mask_next;
            press_timer_reg <= press_timer_next;
        end
    end

endmodule

/* rtl/core/kpd_cmd_fifo.sv */
module kpd_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kpd_pkg::kpd_cmd_t  push_cmd,
    output logic               not_full,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output kpd_pkg::kpd_cmd_t  cmd
);
    import kpd_pkg::*;

    kpd_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign not_full  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/kpd_back.sv */
module kpd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  kpd_pkg::kpd_cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output kpd_pkg::kpd_out_t  out_data
);
    import kpd_pkg::*;

    logic [NUM_KEYS-1:0] code_queue [QUEUE_DEPTH];

    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg;
    kpd_out_t          out_data_reg, out_data_next;
    logic              fire;
    logic              do_write;
    logic [SLOT_W-1:0] wr_slot_inc;
    logic [SLOT_W-1:0] rd_slot_inc;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
        return r;
    endfunction

    assign cmd_ready   = !out_valid_reg || out_ready;
    assign fire        = cmd_valid && cmd_ready;
    assign wr_slot_inc = slot_inc(wr_slot_reg);
    assign rd_slot_inc = slot_inc(rd_slot_reg);
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        count_next   = count_reg;
        do_write     = 1'b0;
        out_data_next.key_code   = '0;
        out_data_next.code_valid = 1'b0;

        case (cmd.op)
            OP_PUSH:
            begin
                do_write     = 1'b1;
                wr_slot_next = wr_slot_inc;
                // full: oldest code is dropped, count holds
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                    rd_slot_next = rd_slot_inc;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            OP_POP:
            begin
                if (count_reg != '0)
                begin
                    out_data_next.key_code   = 16'(code_queue[rd_slot_reg]);
                    out_data_next.code_valid = 1'b1;
                    rd_slot_next = rd_slot_inc;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_FLUSH:
            begin
                rd_slot_next = wr_slot_reg;
                count_next   = '0;
            end
            default: ;
        endcase
        out_data_next.queue_count = 5'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (fire && do_write)
            code_queue[wr_slot_reg] <= cmd.code;
        if (fire)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                wr_slot_reg <= wr_slot_next;
                rd_slot_reg <= rd_slot_next;
                count_reg   <= count_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("code queue count above depth");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.op == OP_FLUSH |=> count_reg == '0 && rd_slot_reg == wr_slot_reg)
        else $error("flush left codes queued");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.op == OP_POP && count_reg == '0
            |=> out_valid_reg && !out_data_reg.code_valid && out_data_reg.key_code == '0)
        else $error("pop of empty queue returned a code");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

/* rtl/core/keypad_debounce_long_press_fifo.sv */
// An accepted item is registered in the command queue, then in the result register, which
// raises out_valid for it.
// Throughput: one item per cycle while the command queue has room; cfg_ready is always high.
// The code queue is a 16-entry register array, one write or read per cycle while results drain.
// Reset (rst_n, async, active low): debounce, shift, long-press state and queue pointers clear,
// registers return to their defaults; the code queue reads as empty at once, no clearing pass.
module keypad_debounce_long_press_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    // item input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kpd_pkg::kpd_in_t               in_data,
    // result output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output kpd_pkg::kpd_out_t              out_data
);
    import kpd_pkg::*;

    logic      in_fire;
    kpd_cmd_t  front_cmd;
    logic      q_not_full;
    logic      q_valid;
    logic      q_ready;
    kpd_cmd_t  q_cmd;

    // User must write registers only while the block is idle (unenforced); no stall needed.
    assign cfg_ready = 1'b1;

    // The front end takes an item whenever the command queue has room; the
    // back end drains it independently, so a stalled result never blocks
    // scanning until the two-entry queue fills.
    assign in_ready = q_not_full;
    assign in_fire  = in_valid && in_ready;

    // Front: debounce, long-press timing, release detection; turns each
    // transfer into a push, pop, flush or count-only command.
    kpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_data   (in_data),
        .cmd       (front_cmd)
    );

    // Short command queue decoupling the two halves.
    kpd_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_cmd  (front_cmd),
        .not_full  (q_not_full),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd)
    );

    // Back: key-code queue (drop-oldest when full) and the result register.
    kpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
